### design/pgc_pkg.sv
package pgc_pkg;

  localparam int unsigned ExpBits = 10;
  localparam int unsigned ExpSize = 1 << ExpBits;
  localparam int unsigned LogW    = 20;
  localparam int unsigned ExpW    = 17;
  localparam int unsigned PixW    = 8;
  localparam int unsigned GammaW  = 8;
  localparam int unsigned ProdW   = LogW + GammaW;

  localparam logic [GammaW-1:0] GammaReset = 8'd10;
  localparam logic [PixW-1:0]   PixMax     = 8'd255;

  typedef logic [LogW-1:0] log_tab_t [256];
  typedef logic [ExpW-1:0] exp_tab_t [ExpSize];

  // truncated integer square root
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = 64'd0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2(x) with 32 fraction bits, by repeated squaring of the mantissa
  function automatic logic [63:0] log2_q32(input logic [7:0] x);
    int unsigned k;
    logic [63:0] m;
    logic [63:0] frac;
    k    = 0;
    frac = 64'd0;
    while ((x >> (k + 1)) != 8'd0) k++;
    m = {56'd0, x} << (31 - k);
    for (int i = 0; i < 32; i++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return (64'(k) << 32) | frac;
  endfunction

  // |log2(p/255)| / 10 in 20 fraction bits, rounded
  function automatic log_tab_t log_table();
    log_tab_t    tab;
    logic [63:0] top;
    logic [63:0] tmp;
    top    = log2_q32(8'd255);
    tab[0] = '0;
    for (int p = 1; p < 256; p++) begin
      tmp    = (top - log2_q32(8'(p)) + 64'd20480) / 64'd40960;
      tab[p] = tmp[LogW-1:0];
    end
    return tab;
  endfunction

  // 2^(-i/1024) in Q16, built from a chain of square roots of one half
  function automatic exp_tab_t exp_table();
    exp_tab_t    tab;
    logic [63:0] c [ExpBits+1];
    logic [63:0] e;
    logic [63:0] tmp;
    c[0] = 64'd0;
    c[1] = isqrt64(64'd1 << 63);
    for (int k = 1; k < ExpBits; k++) c[k+1] = isqrt64(c[k] << 32);
    for (int i = 0; i < ExpSize; i++) begin
      e = 64'd1 << 32;
      for (int k = 1; k <= ExpBits; k++) begin
        if (((i >> (ExpBits - k)) & 1) != 0) e = (e * c[k]) >> 32;
      end
      tmp    = (e + 64'd32768) >> 16;
      tab[i] = tmp[ExpW-1:0];
    end
    return tab;
  endfunction

endpackage

### design/pgc_exp_rom.sv
module pgc_exp_rom
  import pgc_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [ExpBits-1:0]  addr_i,
  output logic [ExpW-1:0]     data_o
);

  localparam exp_tab_t ExpTab = exp_table();

  logic [ExpW-1:0] data_q;

  // registered read, held while the stage stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ExpTab[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

### design/pixel_gamma_correction.sv
// Power-law gamma correction of 8-bit gray pixels: pixel_out = round(255*(p/255)^g), with
// g = gamma_tenths/10, saturated to 0..255. Gamma 0 maps every pixel (pixel 0 too) to 255;
// pixel 0 with nonzero gamma maps to 0. The block takes one pixel per clock while the output
// is not stalled. Each pixel passes in order through the input register, log lookup times
// gamma, exp2 fraction rom (registered read), then scale, round and shift into the output
// register.
// Each stage holds only when the one after it is full and stalled, so a waiting result
// does not stop new pixels from filling empty stages. Both roms are computed at
// elaboration; there is no start-up pass. Write gamma_tenths only while no pixel is in flight.
module pixel_gamma_correction
  import pgc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [GammaW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PixW-1:0]   pixel_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PixW-1:0]   pixel_out_o
);

  localparam log_tab_t LogTab = log_table();

  // gamma register
  logic [GammaW-1:0] gamma_q;

  // stage valids and per-stage advance
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: input word
  logic [PixW-1:0] pix1_q;

  // stage 2: log times gamma
  logic [ProdW-1:0] m_d, m2_q;
  logic             g0_2_q, p0_2_q;

  // stage 3: exp rom output and shift count
  logic [LogW:0]       idx_sum;
  logic [GammaW-1:0]   n_d, n3_q;
  logic                g0_3_q, p0_3_q;
  logic [ExpW-1:0]     exp_data;

  // stage 4: scale, round, shift
  logic [24:0]     prod;
  logic [3:0]      sh;
  logic [25:0]     rnd_sum;
  logic [25:0]     shifted;
  logic [PixW-1:0] out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GammaReset;
    end else if (cfg_we_i) begin
      gamma_q <= cfg_wdata_i;
    end
  end

  // a stage may load when it is empty or its word moves on this cycle
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (rdy1) pix1_q <= pixel_in_i;
  end

  // stage 2: scaled log in Q8.20, never above 2^28
  assign m_d = ProdW'(LogTab[pix1_q]) * ProdW'(gamma_q);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      m2_q   <= m_d;
      g0_2_q <= (gamma_q == '0);
      p0_2_q <= (pix1_q == '0);
    end
  end

  // stage 3: round fraction to 10 bits, a carry out bumps the shift
  assign idx_sum = {1'b0, m2_q[LogW-1:0]} + (LogW+1)'(1 << (LogW - ExpBits - 1));
  assign n_d     = m2_q[ProdW-1:LogW] + GammaW'(idx_sum[LogW]);

  pgc_exp_rom u_exp_rom (
    .clk_i  (clk_i),
    .en_i   (rdy3),
    .addr_i (idx_sum[LogW-1:LogW-ExpBits]),
    .data_o (exp_data)
  );

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      n3_q   <= n_d;
      g0_3_q <= g0_2_q;
      p0_3_q <= p0_2_q;
    end
  end

  // stage 4: 255*exp in Q16, round at the shift point, saturate
  assign prod    = 25'(exp_data) * 25'(PixMax);
  assign sh      = n3_q[3:0];
  assign rnd_sum = {1'b0, prod} + (26'd1 << (5'd15 + 5'(sh)));
  assign shifted = rnd_sum >> (5'd16 + 5'(sh));

  always_comb begin
    if (g0_3_q) begin
      out_d = PixMax;
    end else if (p0_3_q || (n3_q > 8'd8)) begin
      // any shift past eight leaves nothing
      out_d = '0;
    end else if (shifted > 26'(PixMax)) begin
      out_d = PixMax;
    end else begin
      out_d = shifted[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) out_q <= out_d;
  end

  assign out_valid_o = v4_q;
  assign pixel_out_o = out_q;

  // a full pipeline is the only reason to refuse a word
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input refused with an empty stage");

  // a stalled stage 3 keeps its word
  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> (v3_q && $stable(n3_q)))
    else $error("stage 3 word lost while stalled");

  // gamma zero always gives full white
  a_gamma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4 && g0_3_q) |=> (out_valid_o && pixel_out_o == PixMax))
    else $error("gamma zero did not give 255");

  // black stays black under nonzero gamma
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4 && p0_3_q && !g0_3_q) |=> (out_valid_o && pixel_out_o == '0))
    else $error("pixel zero did not give 0");

endmodule

### bench/tb_pixel_gamma_correction.sv
`timescale 1ns / 1ps

module tb_pixel_gamma_correction;
  import pgc_pkg::*;

  // run length guard, far above the slowest legal run
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandPhases   = 3;
  localparam int unsigned SegsPerPhase = 5;
  localparam int unsigned WordsPerSeg  = 67;
  // output register sits four stages behind the input
  localparam int unsigned TailCycles   = 8;

  // one outstanding corrected pixel, with the context it was computed from
  typedef struct {
    logic [PixW-1:0]   pixel_in;
    logic [GammaW-1:0] gamma;
    logic [PixW-1:0]   pixel_out;
  } corrected_pixel_t;

  // predicts the corrected pixel for every accepted word and checks the results in order
  class gamma_scoreboard;
    bit [19:0]         log_q [256];
    bit [16:0]         exp_q [1024];
    logic [GammaW-1:0] gamma;
    corrected_pixel_t  expected_pixels [$];
    int unsigned       mismatches;

    function new();
      bit [63:0] roots [11];
      bit [63:0] top;
      bit [63:0] acc;
      gamma      = GammaReset;
      mismatches = 0;
      // log table: |log2(p/255)| / 10 in 20 fraction bits, rounded
      top      = log2_fix(8'd255);
      log_q[0] = '0;
      for (int p = 1; p < 256; p++)
        log_q[p] = 20'((top - log2_fix(8'(p)) + 64'd20480) / 64'd40960);
      // roots[k] = 2^(-1/2^k) in Q32, by a chain of square roots
      roots[0] = '0;
      roots[1] = int_sqrt(64'd1 << 63);
      for (int k = 1; k < 10; k++) roots[k+1] = int_sqrt(roots[k] << 32);
      // exp2 fraction table in Q16
      for (int i = 0; i < 1024; i++) begin
        acc = 64'd1 << 32;
        for (int k = 1; k <= 10; k++)
          if (i[10-k]) acc = (acc * roots[k]) >> 32;
        exp_q[i] = 17'((acc + 64'd32768) >> 16);
      end
    endfunction

    // bitwise truncated square root
    function bit [63:0] int_sqrt(input bit [63:0] v);
      bit [63:0] r;
      bit [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    // log2 with 32 fraction bits: mantissa squared 32 times, one bit per overflow
    function bit [63:0] log2_fix(input bit [7:0] x);
      int unsigned whole;
      bit [63:0]   mant;
      bit [63:0]   frac;
      whole = 0;
      for (int b = 7; b > 0; b--)
        if (x[b] && whole == 0) whole = b;
      mant = 64'(x) << (31 - whole);
      frac = '0;
      for (int i = 0; i < 32; i++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant >= (64'd1 << 32)) begin
          frac[0] = 1'b1;
          mant    = mant >> 1;
        end
      end
      return (64'(whole) << 32) | frac;
    endfunction

    function logic [PixW-1:0] correct(input logic [PixW-1:0] p);
      bit [63:0] prod;
      bit [63:0] shift;
      bit [63:0] idx;
      bit [63:0] val;
      if (gamma == '0) return PixMax;
      if (p == '0) return '0;
      prod  = 64'(log_q[p]) * 64'(gamma);
      shift = prod >> 20;
      idx   = ((prod & 64'hFFFFF) + 64'd512) >> 10;
      // rounding carried into the next whole power
      if (idx == 64'd1024) begin
        idx   = '0;
        shift = shift + 1;
      end
      if (shift >= 40) return '0;
      val = (64'd255 * 64'(exp_q[idx]) + (64'd1 << (15 + shift))) >> (16 + shift);
      if (val > 64'd255) val = 64'd255;
      return val[PixW-1:0];
    endfunction

    function void set_gamma(input logic [GammaW-1:0] g);
      gamma = g;
    endfunction

    function void note_pixel(input logic [PixW-1:0] p);
      corrected_pixel_t c;
      c.pixel_in  = p;
      c.gamma     = gamma;
      c.pixel_out = correct(p);
      expected_pixels.push_back(c);
    endfunction

    function void check_pixel(input logic [PixW-1:0] actual);
      corrected_pixel_t c;
      if (expected_pixels.size() == 0) begin
        $error("pixel_out: unexpected word, actual %0d", actual);
        mismatches++;
        return;
      end
      c = expected_pixels.pop_front();
      if (actual !== c.pixel_out) begin
        $error("pixel_out mismatch: expected %0d, actual %0d (pixel_in %0d, gamma_tenths %0d)",
               c.pixel_out, actual, c.pixel_in, c.gamma);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [GammaW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [PixW-1:0]   pixel_in_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PixW-1:0]   pixel_out_o;

  gamma_scoreboard sb;
  int unsigned     send_gap_pct   = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycle_count    = 0;

  pixel_gamma_correction u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o)
  );

  always #10 clk_i = ~clk_i;

  // receiver: random stalls at the current rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor, sampled at the edge that moves the word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_pixel(pixel_out_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one pixel, optionally after a random gap, and hold it until taken
  task automatic send_pixel(input logic [PixW-1:0] p);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge; noted here so the drain check cannot miss it
    sb.note_pixel(p);
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // register write, only with the pipe empty
  task automatic write_gamma(input logic [GammaW-1:0] g);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_gamma(g);
  endtask

  // random pixel, with the two ends of the range weighted up
  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return PixMax;
      2:       return PixW'($urandom_range(1, 8));
      default: return PixW'($urandom_range(255));
    endcase
  endfunction

  // random gamma, extremes and the reset value included
  function automatic logic [GammaW-1:0] pick_gamma();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 8'd200;
      2:       return 8'd255;
      3:       return GammaReset;
      4:       return 8'd1;
      default: return GammaW'($urandom_range(255));
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gamma first, then zero, tiny, top of range, above it and 5
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd2);
    send_pixel(8'd127);
    send_pixel(8'd128);
    send_pixel(8'd254);
    send_pixel(8'd255);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    wait_drained();
    // gamma zero maps even pixel zero to full scale
    write_gamma(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    wait_drained();
    write_gamma(8'd1);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd255);
    wait_drained();
    write_gamma(8'd200);
    send_pixel(8'd1);
    send_pixel(8'd2);
    send_pixel(8'd254);
    send_pixel(8'd255);
    wait_drained();
    // register beyond the nominal range is used as written
    write_gamma(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd128);
    send_pixel(8'd255);
    wait_drained();
    write_gamma(8'd5);
    send_pixel(8'd1);
    send_pixel(8'd64);
    wait_drained();

    // random: three idle profiles, several gamma settings in each
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       begin send_gap_pct = 16; recv_stall_pct = 64; end
        1:       begin send_gap_pct = 64; recv_stall_pct = 16; end
        default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int s = 0; s < SegsPerPhase; s++) begin
        write_gamma(pick_gamma());
        for (int w = 0; w < WordsPerSeg; w++) send_pixel(pick_pixel());
        wait_drained();
      end
    end

    recv_stall_pct = 0;
    wait_drained();
    // any stray word in this window shows up as unexpected
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
